### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the waypoint search RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, off while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/nws_pkg.sv
// ---------------------------------------------------------------------------
// nws_pkg
// Shared constants and types of the nearest waypoint search block.
// ---------------------------------------------------------------------------
package nws_pkg;

    // table and coordinate sizing
    localparam int MAX_WAYPOINTS = 256;
    localparam int COORD_BITS    = 24;

    // fixed port field widths
    localparam int CFG_W     = 9;
    localparam int IN_IDX_W  = 8;
    localparam int POS_W     = 24;
    localparam int OUT_IDX_W = 8;
    localparam int DIST_W    = 50;

    // derived widths
    localparam int ADDR_W  = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W   = $clog2(MAX_WAYPOINTS + 1);
    localparam int ENTRY_W = 2 * COORD_BITS;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int SQ_W    = 2 * DIFF_W - 1;
    localparam int SUM_W   = SQ_W + 1;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_we;
        logic query_init;
        logic scan_rd;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic pipe_busy;
        logic count_zero;
    } t_dp_status;

endpackage

### rtl/nws_ram.sv
// ---------------------------------------------------------------------------
// nws_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module nws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/nws_ctrl.sv
// ---------------------------------------------------------------------------
// nws_ctrl
// Sequencer: accepts commands, runs the table scan, drains, strobes result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nws_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                i_command,
    output logic                busy,
    output logic                o_done,
    output nws_pkg::t_dp_cmd    o_cmd,
    input  nws_pkg::t_dp_status i_status
);
    import nws_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign w_accept = start && (r_state == S_IDLE);

    // datapath commands
    assign o_cmd.load_we    = w_accept && (i_command == CMD_LOAD);
    assign o_cmd.query_init = w_accept && (i_command == CMD_QUERY);
    assign o_cmd.scan_rd    = (r_state == S_SCAN);

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.query_init) begin
                    n_state = i_status.count_zero ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result strobe lasts one cycle
    `ASSERT_IMPL(a_done_single, i_clk, i_rst_n, o_done |=> !o_done, "done strobe held")
    // empty-table query answers on the next cycle
    `ASSERT_IMPL(a_empty_fast, i_clk, i_rst_n,
        (o_cmd.query_init && i_status.count_zero) |=> o_done, "empty query not immediate")
    // no scan read once the drain has started
    `ASSERT_NEVER(a_no_read_drain, i_clk, i_rst_n,
        (r_state == S_DRAIN) && o_cmd.scan_rd, "scan read during drain")

endmodule

### rtl/nws_datapath.sv
// ---------------------------------------------------------------------------
// nws_datapath
// Waypoint table, distance pipeline and running minimum.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nws_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [nws_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic [nws_pkg::IN_IDX_W-1:0]       i_entry_index,
    input  logic signed [nws_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [nws_pkg::POS_W-1:0]   i_pos_y,
    input  nws_pkg::t_dp_cmd                   i_cmd,
    output nws_pkg::t_dp_status                o_status,
    output logic [nws_pkg::OUT_IDX_W-1:0]      o_nearest_index,
    output logic [nws_pkg::DIST_W-1:0]         o_min_dist_sq,
    output logic                               o_found
);
    import nws_pkg::*;

    logic [CFG_W-1:0]             r_wp_count;
    logic [CNT_W-1:0]             w_scan_n;
    logic signed [COORD_BITS-1:0] w_in_x;
    logic signed [COORD_BITS-1:0] w_in_y;
    logic                         w_load_ok;
    logic signed [COORD_BITS-1:0] r_qx;
    logic signed [COORD_BITS-1:0] r_qy;
    logic [ADDR_W-1:0]            r_rd_addr;
    logic [ENTRY_W-1:0]           w_rdata;
    logic signed [COORD_BITS-1:0] w_wx;
    logic signed [COORD_BITS-1:0] w_wy;
    // pipeline valids and indexes
    logic                         r_v1, r_v2, r_v3, r_v4;
    logic [ADDR_W-1:0]            r_idx1, r_idx2, r_idx3, r_idx4;
    logic signed [DIFF_W-1:0]     r_dx;
    logic signed [DIFF_W-1:0]     r_dy;
    logic signed [2*DIFF_W-1:0]   w_sqx_full;
    logic signed [2*DIFF_W-1:0]   w_sqy_full;
    logic [SQ_W-1:0]              r_sqx;
    logic [SQ_W-1:0]              r_sqy;
    logic [SUM_W-1:0]             r_dist;
    // running minimum
    logic                         r_found;
    logic [ADDR_W-1:0]            r_best_idx;
    logic [SUM_W-1:0]             r_best_dist;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp_count <= '0;
        end else if (i_cfg_we) begin
            r_wp_count <= i_cfg_wdata;
        end
    end

    // entries searched, clamped to table depth
    assign w_scan_n = (int'(r_wp_count) > MAX_WAYPOINTS) ? CNT_W'(MAX_WAYPOINTS)
                                                         : CNT_W'(r_wp_count);

    // coordinates as table-width two's complement values
    assign w_in_x    = COORD_BITS'(i_pos_x);
    assign w_in_y    = COORD_BITS'(i_pos_y);
    assign w_load_ok = i_cmd.load_we && (int'(i_entry_index) < MAX_WAYPOINTS);

    // waypoint table, {x, y} per entry
    nws_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WAYPOINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_load_ok),
        .i_waddr (ADDR_W'(i_entry_index)),
        .i_wdata ({w_in_x, w_in_y}),
        .i_re    (i_cmd.scan_rd),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    assign w_wx = w_rdata[ENTRY_W-1:COORD_BITS];
    assign w_wy = w_rdata[COORD_BITS-1:0];

    // query point and scan address
    always_ff @(posedge i_clk) begin
        if (i_cmd.query_init) begin
            r_qx      <= w_in_x;
            r_qy      <= w_in_y;
            r_rd_addr <= '0;
        end else if (i_cmd.scan_rd) begin
            r_rd_addr <= r_rd_addr + 1'b1;
        end
    end

    // pipeline valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_rd;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // differences, squares, sum
    assign w_sqx_full = r_dx * r_dx;
    assign w_sqy_full = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_rd_addr;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_idx4 <= r_idx3;
        r_dx   <= DIFF_W'(r_qx) - DIFF_W'(w_wx);
        r_dy   <= DIFF_W'(r_qy) - DIFF_W'(w_wy);
        r_sqx  <= w_sqx_full[SQ_W-1:0];
        r_sqy  <= w_sqy_full[SQ_W-1:0];
        r_dist <= SUM_W'(r_sqx) + SUM_W'(r_sqy);
    end

    // running minimum, strict compare keeps the lower index on ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.query_init) begin
            r_found <= 1'b0;
        end else if (r_v4) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_init) begin
            r_best_idx  <= '0;
            r_best_dist <= '0;
        end else if (r_v4 && (!r_found || (r_dist < r_best_dist))) begin
            r_best_idx  <= r_idx4;
            r_best_dist <= r_dist;
        end
    end

    // status back to the controller
    assign o_status.scan_last  = (CNT_W'(r_rd_addr) + 1'b1) == w_scan_n;
    assign o_status.pipe_busy  = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_status.count_zero = (w_scan_n == '0);

    assign o_nearest_index = OUT_IDX_W'(r_best_idx);
    assign o_min_dist_sq   = DIST_W'(r_best_dist);
    assign o_found         = r_found;

    // scan never reads past the active entry count
    `ASSERT_IMPL(a_rd_in_range, i_clk, i_rst_n,
        i_cmd.scan_rd |-> (CNT_W'(r_rd_addr) < w_scan_n), "scan address out of range")
    // a compared distance always leaves the minimum marked found
    `ASSERT_IMPL(a_found_after_cmp, i_clk, i_rst_n, r_v4 |=> r_found, "found not set")

endmodule

### rtl/nearest_waypoint_search_top.sv
// ---------------------------------------------------------------------------
// nearest_waypoint_search_top
// Nearest waypoint search over a 256-entry table of 2-D waypoints.
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A load (command 0)
// writes one waypoint in that cycle and gives no result. A query (command 1)
// scans entries 0 .. n-1, n = waypoint_count clamped to 256, one entry per
// cycle through the table's single read port, then a four-stage distance
// pipeline drains; the result strobe o_done then rises, busy falls on the
// cycle after, and a new command is taken only once busy is low. An empty
// table answers on the cycle after the transfer with found cleared. o_done
// is high for exactly one cycle and the result fields are only meaningful
// then; the receiver cannot stall it. Entries never loaded hold no defined
// value. Write waypoint_count only while idle.
module nearest_waypoint_search_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [nws_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_command,
    input  logic [nws_pkg::IN_IDX_W-1:0]        i_entry_index,
    input  logic signed [nws_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [nws_pkg::POS_W-1:0]    i_pos_y,
    output logic                                o_done,
    output logic [nws_pkg::OUT_IDX_W-1:0]       o_nearest_index,
    output logic [nws_pkg::DIST_W-1:0]          o_min_dist_sq,
    output logic                                o_found
);
    import nws_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer
    nws_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .busy      (busy),
        .o_done    (o_done),
        .o_cmd     (w_cmd),
        .i_status  (w_status)
    );

    // table and distance datapath
    nws_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_entry_index   (i_entry_index),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_nearest_index (o_nearest_index),
        .o_min_dist_sq   (o_min_dist_sq),
        .o_found         (o_found)
    );

endmodule
